>>> hdl/dca_pkg.sv
// shared constants, types and level bases for the compressed array store
package dca_pkg;

    localparam int CAPACITY   = 4096;
    localparam int LEVELS     = 7;
    localparam int DIGIT_BITS = 4;
    localparam int POS_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int ADDR_W     = LVL_W + POS_W;
    localparam int DEPTH      = LEVELS * CAPACITY;
    localparam int VALUE_W    = 29;
    localparam int INDEX_W    = 13;
    localparam int REM_W      = DIGIT_BITS * LEVELS;
    localparam int ENTRY_W    = DIGIT_BITS + 1 + POS_W;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 29'd286331151;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_ACCESS = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_TOO_BIG  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPEND,
        S_WALK
    } state_t;

    function automatic logic [VALUE_W-1:0] level_base(input logic [LVL_W-1:0] lvl);
        logic [VALUE_W-1:0] b;
        case (lvl)
            3'd0:    b = 29'd0;
            3'd1:    b = 29'd16;
            3'd2:    b = 29'd272;
            3'd3:    b = 29'd4368;
            3'd4:    b = 29'd69904;
            3'd5:    b = 29'd1118480;
            3'd6:    b = 29'd17895696;
            default: b = 29'd0;
        endcase
        return b;
    endfunction

endpackage

>>> hdl/dac_compressed_array_access_top.sv
// directly addressable nibble code store: append and indexed access
//
//  channel | signals                              | role
//  req     | req_valid req_stall operation value index | clear / append / access
//  rsp     | rsp_valid rsp_stall value_out status | one result per request
//
// append writes one entry per level (1 to 7 levels); access reads level 0 first
// and then walks one level at a time (1 to 7 levels) through the entry memory.
// clear, unused codes and rejected requests are answered straight from idle.
// each entry holds digit, stop bit and the slot of its next level digit, so
// no rank count is needed; reset and clear zero the fill counters and the count.
// a request is taken only while idle and the result register is free or draining.
module dac_compressed_array_access_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [1:0]                   operation,
    input  logic [dca_pkg::VALUE_W-1:0]  value,
    input  logic [dca_pkg::INDEX_W-1:0]  index,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [dca_pkg::VALUE_W-1:0]  value_out,
    output logic [1:0]                   status
);

    localparam int LVL_W = dca_pkg::LVL_W;
    localparam int POS_W = dca_pkg::POS_W;
    localparam int CNT_W = dca_pkg::CNT_W;
    localparam int DB    = dca_pkg::DIGIT_BITS;

    dca_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]           fill_reg [dca_pkg::LEVELS];
    logic [CNT_W-1:0]           fill_next [dca_pkg::LEVELS];
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [LVL_W-1:0]           lvl_reg, lvl_next;
    logic [LVL_W-1:0]           top_reg, top_next;
    logic [dca_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [dca_pkg::REM_W-1:0]  sum_reg, sum_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    logic [dca_pkg::VALUE_W-1:0] value_out_reg, value_out_next;
    logic [1:0]                 status_reg, status_next;

    logic [dca_pkg::ENTRY_W-1:0] mem [dca_pkg::DEPTH];
    logic [dca_pkg::ENTRY_W-1:0] rd_data;
    logic [dca_pkg::ADDR_W-1:0]  rd_addr;
    logic [dca_pkg::ADDR_W-1:0]  wr_addr;
    logic [dca_pkg::ENTRY_W-1:0] wr_data;
    logic                        wr_en;

    logic                        accept;
    logic                        rsp_free;
    logic [LVL_W-1:0]            sel_lvl;
    logic [DB-1:0]               rd_digit;
    logic                        rd_stop;
    logic [POS_W-1:0]            rd_ptr;
    logic [dca_pkg::REM_W-1:0]   sum_add;
    logic [POS_W-1:0]            wr_ptr;

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != dca_pkg::S_IDLE) || !rsp_free;
    assign accept    = req_valid && !req_stall;

    assign rsp_valid = rsp_valid_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;

    assign rd_digit = rd_data[dca_pkg::ENTRY_W-1 -: DB];
    assign rd_stop  = rd_data[POS_W];
    assign rd_ptr   = rd_data[POS_W-1:0];

    // highest level whose base the value reaches
    always_comb
    begin
        sel_lvl = '0;
        for (int l = 0; l < dca_pkg::LEVELS; l++)
        begin
            if (value >= dca_pkg::level_base(LVL_W'(l)))
                sel_lvl = LVL_W'(l);
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dca_pkg::S_IDLE:
            begin
                if (accept && operation == dca_pkg::OP_APPEND
                    && count_reg < CNT_W'(dca_pkg::CAPACITY) && value <= dca_pkg::VALUE_MAX)
                    state_next = dca_pkg::S_APPEND;
                else if (accept && operation == dca_pkg::OP_ACCESS && index != '0
                         && index <= dca_pkg::INDEX_W'(count_reg))
                    state_next = dca_pkg::S_WALK;
            end
            dca_pkg::S_APPEND:
            begin
                if (lvl_reg == top_reg)
                    state_next = dca_pkg::S_IDLE;
            end
            dca_pkg::S_WALK:
            begin
                if (rd_stop || lvl_reg == LVL_W'(dca_pkg::LEVELS - 1))
                    state_next = dca_pkg::S_IDLE;
            end
            default: state_next = dca_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        fill_next      = fill_reg;
        count_next     = count_reg;
        lvl_next       = lvl_reg;
        top_next       = top_reg;
        rem_next       = rem_reg;
        sum_next       = sum_reg;
        value_out_next = value_out_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        wr_ptr         = '0;
        sum_add        = '0;
        rd_addr        = {LVL_W'(0), POS_W'(index - 1'b1)};
        wr_addr        = {lvl_reg, fill_reg[lvl_reg][POS_W-1:0]};
        wr_data        = '0;
        case (state_reg)
            dca_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    lvl_next       = '0;
                    sum_next       = '0;
                    top_next       = sel_lvl;
                    rem_next       = dca_pkg::REM_W'(value - dca_pkg::level_base(sel_lvl));
                    value_out_next = '0;
                    status_next    = dca_pkg::ST_OK;
                    rsp_valid_next = 1'b1;
                    case (operation)
                        dca_pkg::OP_CLEAR:
                        begin
                            for (int l = 0; l < dca_pkg::LEVELS; l++)
                                fill_next[l] = '0;
                            count_next = '0;
                        end
                        dca_pkg::OP_APPEND:
                        begin
                            if (count_reg >= CNT_W'(dca_pkg::CAPACITY))
                                status_next = dca_pkg::ST_FULL;
                            else if (value > dca_pkg::VALUE_MAX)
                                status_next = dca_pkg::ST_TOO_BIG;
                            else
                                rsp_valid_next = 1'b0;
                        end
                        dca_pkg::OP_ACCESS:
                        begin
                            if (index == '0 || index > dca_pkg::INDEX_W'(count_reg))
                                status_next = dca_pkg::ST_RANGE;
                            else
                                rsp_valid_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            dca_pkg::S_APPEND:
            begin
                // continuation slot is where the next level fills next
                if (lvl_reg != LVL_W'(dca_pkg::LEVELS - 1))
                    wr_ptr = fill_reg[lvl_reg + 1'b1][POS_W-1:0];
                wr_en   = 1'b1;
                wr_data = {rem_reg[DB-1:0], lvl_reg == top_reg, wr_ptr};
                fill_next[lvl_reg] = fill_reg[lvl_reg] + 1'b1;
                rem_next = rem_reg >> DB;
                lvl_next = lvl_reg + 1'b1;
                if (lvl_reg == top_reg)
                begin
                    count_next     = count_reg + 1'b1;
                    value_out_next = '0;
                    status_next    = dca_pkg::ST_OK;
                    rsp_valid_next = 1'b1;
                end
            end
            dca_pkg::S_WALK:
            begin
                sum_add  = dca_pkg::REM_W'(rd_digit) << (DB * lvl_reg);
                sum_next = sum_reg | sum_add;
                rd_addr  = {LVL_W'(lvl_reg + 1'b1), rd_ptr};
                lvl_next = lvl_reg + 1'b1;
                if (rd_stop || lvl_reg == LVL_W'(dca_pkg::LEVELS - 1))
                begin
                    value_out_next = dca_pkg::VALUE_W'(sum_next)
                                     + dca_pkg::level_base(lvl_reg);
                    status_next    = dca_pkg::ST_OK;
                    rsp_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dca_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            for (int l = 0; l < dca_pkg::LEVELS; l++)
                fill_reg[l] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg       <= lvl_next;
        top_reg       <= top_next;
        rem_reg       <= rem_next;
        sum_reg       <= sum_next;
        value_out_reg <= value_out_next;
        status_reg    <= status_next;
    end

endmodule

>>> sim/tb_top.sv
// self-checking testbench for the nibble code store: directed and random requests checked against a predictor
class dac_scoreboard;
    logic [28:0] exp_value[$];
    logic [1:0]  exp_status[$];
    int          errors;

    // stored element values mirror the store; encoding does not change values
    logic [28:0] elems[$];

    function void note_request(logic [1:0] op, logic [28:0] v, logic [12:0] idx);
        logic [28:0] rv;
        logic [1:0]  st;
        rv = '0;
        st = dca_pkg::ST_OK;
        case (op)
            dca_pkg::OP_CLEAR:  elems.delete();
            dca_pkg::OP_APPEND:
            begin
                if (elems.size() >= dca_pkg::CAPACITY)
                    st = dca_pkg::ST_FULL;
                else if (v > dca_pkg::VALUE_MAX)
                    st = dca_pkg::ST_TOO_BIG;
                else
                    elems.push_back(v);
            end
            dca_pkg::OP_ACCESS:
            begin
                if (idx == 0 || idx > elems.size())
                    st = dca_pkg::ST_RANGE;
                else
                    rv = elems[idx - 1];
            end
            default: ;
        endcase
        exp_value.push_back(rv);
        exp_status.push_back(st);
    endfunction

    function void check_result(logic [28:0] v, logic [1:0] st);
        logic [28:0] ev;
        logic [1:0]  es;
        if (exp_value.size() == 0)
        begin
            $error("result with no request pending: value_out %0d status %0d", v, st);
            errors++;
            return;
        end
        ev = exp_value.pop_front();
        es = exp_status.pop_front();
        if (v !== ev)
        begin
            $error("value_out: expected %0d, got %0d", ev, v);
            errors++;
        end
        if (st !== es)
        begin
            $error("status: expected %0d, got %0d", es, st);
            errors++;
        end
    endfunction
endclass

module tb_top;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  operation;
    logic [28:0] value;
    logic [12:0] index;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [28:0] value_out;
    logic [1:0]  status;

    dac_scoreboard sb;
    int  cycles;
    bit  quiet;     // no idling on either side
    int  fill_est;  // element count as seen by the sender

    dac_compressed_array_access_top dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .operation(operation), .value(value), .index(index),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .value_out(value_out), .status(status)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        sb = new();
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (rst_n && rsp_valid && !rsp_stall)
                sb.check_result(value_out, status);
            if (cycles > 400000)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // receiver stalls at random except in quiet stretches
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_stall <= !quiet && ($urandom_range(99) < 15);
        end
    end

    task automatic send(logic [1:0] op, logic [28:0] v, logic [12:0] idx);
        while (!quiet && $urandom_range(99) < 15)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        value     <= v;
        index     <= idx;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(op, v, idx);
        if (op == dca_pkg::OP_CLEAR)
            fill_est = 0;
        else if (op == dca_pkg::OP_APPEND && v <= dca_pkg::VALUE_MAX
                 && fill_est < dca_pkg::CAPACITY)
            fill_est++;
        @(negedge clk);
    endtask

    function automatic logic [28:0] rand_value();
        int lvl;
        lvl = $urandom_range(7);
        if (lvl == 7)
            return 29'($urandom_range(dca_pkg::VALUE_MAX, 29'h1FFFFFFF));
        if (lvl == 6)
            return 29'($urandom_range(dca_pkg::level_base(3'd6), dca_pkg::VALUE_MAX));
        return 29'($urandom_range(dca_pkg::level_base(lvl[2:0]),
                                  dca_pkg::level_base(lvl[2:0] + 3'd1) - 29'd1));
    endfunction

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.exp_value.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int k;
        int r;
        rst_n = 1'b0;
        req_valid = 1'b0;
        operation = dca_pkg::OP_NONE;
        value = '0;
        index = '0;
        quiet = 1'b0;
        fill_est = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty access, every level edge, limits, unused code
        send(dca_pkg::OP_ACCESS, '0, 13'd1);
        send(dca_pkg::OP_ACCESS, '0, 13'd0);
        for (k = 0; k < 7; k++)
        begin
            send(dca_pkg::OP_APPEND, dca_pkg::level_base(k[2:0]), '0);
            send(dca_pkg::OP_APPEND, (k == 6) ? dca_pkg::VALUE_MAX
                 : dca_pkg::level_base(k[2:0] + 3'd1) - 29'd1, '0);
        end
        send(dca_pkg::OP_APPEND, dca_pkg::VALUE_MAX + 29'd1, '0);
        send(dca_pkg::OP_APPEND, 29'h1FFFFFFF, '0);
        send(dca_pkg::OP_NONE, 29'h1FFFFFFF, 13'h1FFF);
        for (k = 1; k <= 15; k += 2)
            send(dca_pkg::OP_ACCESS, '0, k[12:0]);
        send(dca_pkg::OP_ACCESS, '0, 13'd14);
        send(dca_pkg::OP_ACCESS, '0, 13'd15);
        send(dca_pkg::OP_ACCESS, '0, 13'h1FFF);
        send(dca_pkg::OP_CLEAR, '0, '0);
        send(dca_pkg::OP_ACCESS, '0, 13'd1);

        // random: mostly appends and reads of written entries
        for (k = 0; k < 620; k++)
        begin
            quiet = (k >= 250 && k < 350);
            if (k == 500)
            begin
                drain();
                repeat (10) @(negedge clk);
            end
            r = $urandom_range(99);
            if (r < 2)
                send(dca_pkg::OP_CLEAR, 29'($urandom), 13'($urandom));
            else if (r < 4)
                send(dca_pkg::OP_NONE, 29'($urandom), 13'($urandom));
            else if (r < 45)
                send(dca_pkg::OP_APPEND, rand_value(), 13'($urandom));
            else if (r < 50 || fill_est == 0)
                send(dca_pkg::OP_ACCESS, 29'($urandom), 13'($urandom));
            else
                send(dca_pkg::OP_ACCESS, 29'($urandom), 13'($urandom_range(fill_est, 1)));
        end
        quiet = 1'b0;

        drain();
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.exp_value.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
